[src/assert_macros.svh]
// Assertion macros for the prime sieve RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[src/ips_pkg.sv]
// Package for the incremental prime sieve: codes, constants and the
// controller/datapath command and status types. No dependencies.
`default_nettype none
package ips_pkg;
  localparam int unsigned DefaultPrimeDepth = 4096;
  localparam int unsigned WordWidth = 64;
  localparam logic [63:0] TopValue = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_PRIME = 3'd0, ST_COMPOSITE = 3'd1, ST_UNDECIDED = 3'd2,
    ST_LOADED = 3'd3, ST_FULL = 3'd4, ST_LIMIT = 3'd5
  } status_t;

  localparam logic OP_TEST = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_PRIMES = 2'd1;
  localparam logic [1:0] REG_COMPOSITES = 2'd2;

  typedef struct packed {
    logic    start;     // latch the item, begin
    logic    rd_issue;  // issue table read at walk index
    logic    div_start; // start divider with read entry
    logic    finish;    // commit result with given status
    status_t fin_status;
  } ips_cmd_t;

  typedef struct packed {
    logic is_load;
    logic at_limit;
    logic table_full;
    logic walk_end;   // walk index reached fill
    logic entry_zero;
    logic div_done;
    logic is_div;     // divides and not equal
    logic stop_prime; // divisor not below quotient
  } ips_stat_t;
endpackage
`default_nettype wire

[src/ips_if.sv]
// Valid/ready channel interfaces for the prime sieve.
// Depends on nothing.
`default_nettype none
interface ips_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] seed_prime;
  modport source (output valid, operation, seed_prime, input ready);
  modport sink (input valid, operation, seed_prime, output ready);
endinterface

interface ips_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tested_number;
  logic [2:0]  status;
  logic        stored;
  logic [63:0] primes_found;
  logic [63:0] composites_found;
  modport source (output valid, tested_number, status, stored, primes_found,
                  composites_found, input ready);
  modport sink (input valid, tested_number, status, stored, primes_found,
                composites_found, output ready);
endinterface

interface ips_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/ips_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses ips_pkg.
`default_nettype none
module ips_div
  import ips_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient,
  output logic [63:0]      remainder
);
  logic [63:0] num;
  logic [63:0] den;
  logic [64:0] rem;
  logic [6:0]  count;
  logic        busy;
  logic [64:0] trial;
  logic [64:0] shifted;

  assign shifted = {rem[63:0], num[63]};
  assign trial = shifted - {1'b0, den};
  assign remainder = rem[63:0];
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd0;
        num <= dividend;
        den <= divisor;
        rem <= '0;
      end else if (busy) begin
        if (trial[64]) begin
          rem <= shifted;
          num <= {num[62:0], 1'b0};
        end else begin
          rem <= trial;
          num <= {num[62:0], 1'b1};
        end
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[src/ips_datapath.sv]
// Datapath of the prime sieve: candidate, tallies, prime table memory,
// divider and result register. Uses ips_pkg and ips_div.
`default_nettype none
module ips_datapath
  import ips_pkg::*;
#(
  parameter int unsigned PRIME_DEPTH = DefaultPrimeDepth
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire ips_cmd_t cmd,
  output ips_stat_t    stat,
  input  wire logic    in_operation,
  input  wire logic [63:0] in_seed,
  input  wire logic    cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [63:0] cfg_data,
  output logic [63:0]  res_tested,
  output logic [2:0]   res_status,
  output logic         res_stored,
  output logic [63:0]  res_primes,
  output logic [63:0]  res_composites
);
  localparam int unsigned AW = $clog2(PRIME_DEPTH);
  localparam int unsigned FW = $clog2(PRIME_DEPTH + 1);
  localparam logic [FW-1:0] FullCount = FW'(PRIME_DEPTH);

  logic [63:0] mem [PRIME_DEPTH];
  logic [63:0] rd_data;
  logic [63:0] candidate;
  logic [63:0] tally_p;
  logic [63:0] tally_c;
  logic [FW-1:0] fill;
  logic [FW-1:0] walk;
  logic        op;
  logic [63:0] seed;
  logic [63:0] number;
  logic [63:0] divisor;
  logic        div_done;
  logic [63:0] quo;
  logic [63:0] rem;
  logic        wr_en;
  logic [63:0] wr_val;
  logic [63:0] tally_p_next;
  logic [63:0] tally_c_next;

  ips_div u_div (
    .clk, .rst, .start(cmd.div_start), .dividend(number), .divisor(rd_data),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= mem[walk[AW-1:0]];
    end
    if (wr_en) begin
      mem[fill[AW-1:0]] <= wr_val;
    end
    if (cmd.div_start) begin
      divisor <= rd_data;
    end
  end

  assign stat.is_load = op;
  assign stat.at_limit = candidate > (TopValue - 64'd2);
  assign stat.table_full = fill >= FullCount;
  assign stat.walk_end = (walk >= fill) || (walk >= FullCount);
  assign stat.entry_zero = rd_data == 64'd0;
  assign stat.div_done = div_done;
  assign stat.is_div = (rem == 64'd0) && (divisor != number);
  assign stat.stop_prime = divisor >= quo;

  assign wr_en = cmd.finish && !stat.table_full &&
                 ((cmd.fin_status == ST_LOADED) || (cmd.fin_status == ST_PRIME));
  assign wr_val = (cmd.fin_status == ST_LOADED) ? seed : number;
  assign tally_p_next = (tally_p == TopValue) ? tally_p : tally_p + 64'd1;
  assign tally_c_next = (tally_c == TopValue) ? tally_c : tally_c + 64'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate <= 64'd1;
      tally_p <= '0;
      tally_c <= '0;
      fill <= '0;
      walk <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START: candidate <= cfg_data;
          REG_PRIMES: tally_p <= cfg_data;
          REG_COMPOSITES: tally_c <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start) begin
        op <= in_operation;
        seed <= in_seed;
        number <= candidate + 64'd2;
        walk <= '0;
      end
      if (cmd.rd_issue) begin
        walk <= walk + FW'(1);
      end
      if (wr_en) begin
        fill <= fill + FW'(1);
      end
      if (cmd.finish) begin
        res_status <= cmd.fin_status;
        res_stored <= wr_en;
        res_tested <= ((cmd.fin_status == ST_LOADED) || (cmd.fin_status == ST_FULL) ||
                       (cmd.fin_status == ST_LIMIT)) ? candidate : number;
        res_primes <= (cmd.fin_status == ST_PRIME) ? tally_p_next : tally_p;
        res_composites <= (cmd.fin_status == ST_COMPOSITE) ? tally_c_next : tally_c;
        if (cmd.fin_status == ST_PRIME) begin
          tally_p <= tally_p_next;
          candidate <= number;
        end
        if (cmd.fin_status == ST_COMPOSITE) begin
          tally_c <= tally_c_next;
          candidate <= number;
        end
      end
    end
  end
endmodule
`default_nettype wire

[src/ips_ctrl.sv]
// Controller of the prime sieve: walks the table, sequences reads and
// divisions, and runs the channel handshakes. Uses ips_pkg and the macros.
`default_nettype none
`include "assert_macros.svh"
module ips_ctrl
  import ips_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output ips_cmd_t  cmd,
  input  wire ips_stat_t stat
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DISPATCH = 6'b000010, S_READ = 6'b000100,
    S_CHECK = 6'b001000, S_DIV = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.fin_status = ST_PRIME;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_load) begin
          cmd.finish = 1'b1;
          cmd.fin_status = stat.table_full ? ST_FULL : ST_LOADED;
          state_next = S_OUT;
        end else if (stat.at_limit) begin
          cmd.finish = 1'b1;
          cmd.fin_status = ST_LIMIT;
          state_next = S_OUT;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.walk_end) begin
          cmd.finish = 1'b1;
          cmd.fin_status = ST_UNDECIDED;
          state_next = S_OUT;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.entry_zero) begin
          state_next = S_READ;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (stat.is_div) begin
            cmd.finish = 1'b1;
            cmd.fin_status = ST_COMPOSITE;
            state_next = S_OUT;
          end else if (stat.stop_prime) begin
            cmd.finish = 1'b1;
            cmd.fin_status = ST_PRIME;
            state_next = S_OUT;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_IMPLIES(a_onehot, clk, rst, 1'b1, $onehot(state))
  `ASSERT_NEXT(a_finish_out, clk, rst, cmd.finish, state == S_OUT)
  `ASSERT_IMPLIES(a_div_only_check, clk, rst, cmd.div_start, state == S_CHECK)
  `ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

[src/incremental_prime_sieve.sv]
// Top level of the incremental prime sieve: controller plus datapath.
// Uses ips_pkg, ips_if, ips_ctrl and ips_datapath.
//
// One item at a time. A load or a limit case passes the idle and dispatch
// states before the output handshake. A test walks the table: each entry
// costs a registered memory read and each nonzero one a bit-serial
// division, which sets the rate. Configuration writes are taken at any
// time; one that meets a result commit to the same register loses to it.
`default_nettype none
module incremental_prime_sieve
  import ips_pkg::*;
#(
  parameter int unsigned PRIME_DEPTH = DefaultPrimeDepth
) (
  input wire logic clk,
  input wire logic rst,
  ips_in_if.sink   in_ch,
  ips_out_if.source out_ch,
  ips_cfg_if.sink  cfg
);
  ips_cmd_t  cmd;
  ips_stat_t stat;

  assign cfg.ready = 1'b1;

  ips_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd, .stat
  );

  ips_datapath #(.PRIME_DEPTH(PRIME_DEPTH)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_operation(in_ch.operation), .in_seed(in_ch.seed_prime),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .res_tested(out_ch.tested_number), .res_status(out_ch.status),
    .res_stored(out_ch.stored), .res_primes(out_ch.primes_found),
    .res_composites(out_ch.composites_found)
  );
endmodule
`default_nettype wire
